// ----- src/repeat_counting_table_ranked_report_macros.svh -----
// assertion macros for the repeat counting table
`ifndef REPEAT_COUNTING_TABLE_RANKED_REPORT_MACROS_SVH
`define REPEAT_COUNTING_TABLE_RANKED_REPORT_MACROS_SVH
// implication checked every cycle outside reset
`define RCT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication checked outside reset
`define RCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- src/rctrr_pkg.sv -----
// shared types and constants for the repeat counting table
`default_nettype none
package rctrr_pkg;
   localparam logic [2:0] ST_NEW     = 3'd0;
   localparam logic [2:0] ST_COUNTED = 3'd1;
   localparam logic [2:0] ST_IGNORED = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;
   localparam logic       OP_ADD     = 1'b0;
   localparam logic       OP_REPORT  = 1'b1;
   localparam logic       REG_SORT_DESC = 1'b0;
   localparam logic       REG_LIMIT     = 1'b1;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [3:0] {
      S_IDLE, S_SRD, S_SCMP, S_SORT_I, S_SORT_RDJ, S_SORT_CMP, S_SORT_PUT,
      S_REP_RD, S_REP_OUT, S_OUT
   } state_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] pay;
      logic [15:0] cnt;
   } entry_type;
endpackage
`default_nettype wire

// ----- src/repeat_counting_table_ranked_report.sv -----
// top level: repeat counting table with stable sorted report
//
// req_ channel takes items: opcode 0 adds an occurrence of req_entry_id,
// opcode 1 sorts the table by count and reports up to report_limit entries.
// rsp_ channel returns results; an add gives one result, a report one per
// emitted entry with rsp_is_last on the final one. csr_ writes registers
// (index 0 sort_descending, index 1 report_limit); the user writes them only
// while the block is idle, which the block does not enforce. all entries live
// in one synchronous memory with a registered read; the sequencer issues at
// most one read and one write a cycle. an add scans the entries one at a time,
// a read and then a compare for each; a report runs an insertion sort of the
// table, then reads and emits entries in turn. one item is worked on at a time.
// reset clears the entry count and registers; entry contents are not cleared.
// when the receiver stalls the result holds in the output register and the
// sequencer waits; no item is accepted until the item's results are all taken.
`default_nettype none
module repeat_counting_table_ranked_report #(
   parameter int CAPACITY = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [31:0] req_entry_id,
   input  wire logic [31:0] req_payload,
   input  wire logic        req_has_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_out_id,
   output logic [31:0]      rsp_out_payload,
   output logic [15:0]      rsp_repeat_count,
   output logic             rsp_is_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // entry memory
   rctrr_pkg::entry_type mem [CAPACITY];
   rctrr_pkg::entry_type rd_q;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   rctrr_pkg::entry_type wr_data;
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_q <= mem[rd_addr];
   end

   // control registers
   rctrr_pkg::state_type state_ff, state_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic          desc_ff;
   logic [6:0]    limit_ff;
   logic          has_ff, has_in;
   logic [31:0]   id_ff, id_in, pay_ff, pay_in;
   rctrr_pkg::entry_type key_ff, key_in;
   logic [CW-1:0] n_ff, n_in;
   logic          ov_ff, ov_in;
   logic          last_ff, last_in;
   logic          kind_ff, kind_in;
   logic [2:0]    st_ff, st_in;
   rctrr_pkg::entry_type oe_ff, oe_in;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         desc_ff  <= 1'b1;
         limit_ff <= 7'd3;
      end else if (csr_valid) begin
         case (csr_index)
            rctrr_pkg::REG_SORT_DESC: desc_ff  <= csr_wdata[0];
            rctrr_pkg::REG_LIMIT:     limit_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // report length: clamp limit to 1..64 and bound by table fill
   logic [6:0] lim_c;
   logic [6:0] nrep;
   always_comb begin
      lim_c = (limit_ff == 7'd0) ? 7'd1 : ((limit_ff > 7'd64) ? 7'd64 : limit_ff);
      nrep  = (7'(used_ff) < lim_c) ? 7'(used_ff) : lim_c;
   end

   // key must move before the entry read at j-1 in the sort
   logic ooo;
   assign ooo = desc_ff ? (rd_q.cnt < key_ff.cnt) : (rd_q.cnt > key_ff.cnt);

   assign rsp_valid        = ov_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_status       = st_ff;
   assign rsp_out_id       = oe_ff.id;
   assign rsp_out_payload  = oe_ff.pay;
   assign rsp_repeat_count = oe_ff.cnt;
   assign rsp_is_last      = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rctrr_pkg::S_IDLE;
         used_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         ov_ff    <= ov_in;
      end
      i_ff <= i_in;  j_ff <= j_in;  has_ff <= has_in;
      id_ff <= id_in;  pay_ff <= pay_in;  key_ff <= key_in;  n_ff <= n_in;
      last_ff <= last_in;  kind_ff <= kind_in;
      st_ff <= st_in;  oe_ff <= oe_in;
   end

   always_comb begin
      state_in = state_ff;  used_in = used_ff;  ov_in = ov_ff;
      i_in = i_ff;  j_in = j_ff;  has_in = has_ff;
      id_in = id_ff;  pay_in = pay_ff;  key_in = key_ff;  n_in = n_ff;
      last_in = last_ff;  kind_in = kind_ff;
      st_in = st_ff;  oe_in = oe_ff;
      rd_en = 1'b0;  rd_addr = '0;  wr_en = 1'b0;  wr_addr = '0;
      wr_data = key_ff;
      req_ready = 1'b0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (state_ff)
         rctrr_pkg::S_IDLE: begin
            req_ready = !ov_ff;
            if (req_valid && !ov_ff) begin
               id_in = req_entry_id;
               pay_in = req_payload;  has_in = req_has_payload;
               i_in = '0;
               if (req_opcode == rctrr_pkg::OP_ADD) state_in = rctrr_pkg::S_SRD;
               else begin
                  i_in = CW'(1);
                  state_in = rctrr_pkg::S_SORT_I;
               end
            end
         end
         // add: search entries one by one
         rctrr_pkg::S_SRD: begin
            if (!has_ff) begin
               kind_in = 1'b0;  st_in = rctrr_pkg::ST_IGNORED;
               oe_in = '{id: id_ff, pay: 32'd0, cnt: 16'd0};
               state_in = rctrr_pkg::S_OUT;
            end else if (i_ff >= used_ff) begin
               kind_in = 1'b0;
               if (used_ff == CW'(CAPACITY)) begin
                  st_in = rctrr_pkg::ST_FULL;
                  oe_in = '{id: id_ff, pay: 32'd0, cnt: 16'd0};
               end else begin
                  st_in = rctrr_pkg::ST_NEW;
                  oe_in = '{id: id_ff, pay: pay_ff, cnt: 16'd0};
                  wr_en = 1'b1;  wr_addr = AW'(used_ff);  wr_data = oe_in;
                  used_in = used_ff + CW'(1);
               end
               state_in = rctrr_pkg::S_OUT;
            end else begin
               rd_en = 1'b1;  rd_addr = AW'(i_ff);
               state_in = rctrr_pkg::S_SCMP;
            end
         end
         rctrr_pkg::S_SCMP: begin
            if (rd_q.id == id_ff) begin
               oe_in = rd_q;
               if (rd_q.cnt != rctrr_pkg::COUNT_MAX) oe_in.cnt = rd_q.cnt + 16'd1;
               wr_en = 1'b1;  wr_addr = AW'(i_ff);  wr_data = oe_in;
               kind_in = 1'b0;  st_in = rctrr_pkg::ST_COUNTED;
               state_in = rctrr_pkg::S_OUT;
            end else begin
               i_in = i_ff + CW'(1);
               state_in = rctrr_pkg::S_SRD;
            end
         end
         // report: insertion sort, key register holds entry i
         rctrr_pkg::S_SORT_I: begin
            if (used_ff == '0) begin
               kind_in = 1'b1;  st_in = rctrr_pkg::ST_EMPTY;
               oe_in = '0;
               state_in = rctrr_pkg::S_OUT;
            end else if (i_ff >= used_ff) begin
               i_in = '0;  n_in = CW'(nrep);
               state_in = rctrr_pkg::S_REP_RD;
            end else begin
               rd_en = 1'b1;  rd_addr = AW'(i_ff);
               j_in = i_ff;
               state_in = rctrr_pkg::S_SORT_RDJ;
            end
         end
         rctrr_pkg::S_SORT_RDJ: begin
            if (j_ff == i_ff) key_in = rd_q;
            if (j_ff == '0) state_in = rctrr_pkg::S_SORT_PUT;
            else begin
               rd_en = 1'b1;  rd_addr = AW'(j_ff - CW'(1));
               state_in = rctrr_pkg::S_SORT_CMP;
            end
         end
         rctrr_pkg::S_SORT_CMP: begin
            if (ooo) begin
               wr_en = 1'b1;  wr_addr = AW'(j_ff);  wr_data = rd_q;
               j_in = j_ff - CW'(1);
               if (j_ff == CW'(1)) state_in = rctrr_pkg::S_SORT_PUT;
               else begin
                  rd_en = 1'b1;  rd_addr = AW'(j_ff - CW'(2));
                  state_in = rctrr_pkg::S_SORT_CMP;
               end
            end else state_in = rctrr_pkg::S_SORT_PUT;
         end
         rctrr_pkg::S_SORT_PUT: begin
            wr_en = 1'b1;  wr_addr = AW'(j_ff);  wr_data = key_ff;
            i_in = i_ff + CW'(1);
            state_in = rctrr_pkg::S_SORT_I;
         end
         // report emission, one entry per read
         rctrr_pkg::S_REP_RD: begin
            if (!ov_ff || rsp_ready) begin
               rd_en = 1'b1;  rd_addr = AW'(i_ff);
               state_in = rctrr_pkg::S_REP_OUT;
            end
         end
         rctrr_pkg::S_REP_OUT: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;  kind_in = 1'b1;  st_in = rctrr_pkg::ST_NEW;
               oe_in = rd_q;
               last_in = (i_ff + CW'(1) == n_ff);
               i_in = i_ff + CW'(1);
               state_in = (i_ff + CW'(1) == n_ff) ? rctrr_pkg::S_IDLE
                                                  : rctrr_pkg::S_REP_RD;
            end
         end
         rctrr_pkg::S_OUT: begin
            ov_in = 1'b1;  last_in = 1'b1;
            state_in = rctrr_pkg::S_IDLE;
         end
         default: state_in = rctrr_pkg::S_IDLE;
      endcase
   end

   // rd_q holds its value when no read is issued; S_SORT_RDJ with j==i sees
   // entry i from S_SORT_I, and S_SORT_CMP always follows a read of j-1

`include "repeat_counting_table_ranked_report_macros.svh"
   `RCT_ASSERT_IMP(a_used_bound, 1'b1, used_ff <= CW'(CAPACITY), "entry count overflow")
   `RCT_ASSERT_IMP(a_no_accept_busy, req_valid && req_ready, !ov_ff, "accept with result pending")
   `RCT_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_id), "result lost")
   `RCT_ASSERT_IMP(a_wr_range, wr_en, CW'(wr_addr) < CW'(CAPACITY), "write past capacity")
endmodule
`default_nettype wire
